### rtl/core/wfjd_pkg.sv
`default_nettype none

package wfjd_pkg;

	// Field widths fixed by the sample and result formats
	localparam int CornerBits    = 16;
	localparam int TimeBits      = 32;
	localparam int TimeInBits    = 32;
	localparam int WeightBits    = 18;
	localparam int ReportBits    = 19;

	// Configuration register widths
	localparam int IntervalBits  = 16;
	localparam int ThresholdBits = 18;
	localparam int TareBits      = 18;
	localparam int LedOnBits     = 16;
	localparam int LedOffBits    = 20;

	// Configuration port geometry
	localparam int AddrBits      = 5;
	localparam int DataBits      = 32;
	localparam int IndexBits     = 3;

	// Register values after reset
	localparam logic [IntervalBits-1:0]  ResetPublishInterval = IntervalBits'(100);
	localparam logic [ThresholdBits-1:0] ResetJumpThreshold   = ThresholdBits'(2000);
	localparam logic [TareBits-1:0]      ResetTareOffset      = '0;
	localparam logic                     ResetLedForced       = 1'b0;
	localparam logic [LedOnBits-1:0]     ResetLedOn           = LedOnBits'(125);
	localparam logic [LedOffBits-1:0]    ResetLedOff          = LedOffBits'(120000);

	typedef enum logic [IndexBits-1:0] {
		RegPublishInterval = 3'd0,
		RegJumpThreshold   = 3'd1,
		RegTareOffset      = 3'd2,
		RegLedForced       = 3'd3,
		RegLedOn           = 3'd4,
		RegLedOff          = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic [IntervalBits-1:0]         publish_interval_ms;
		logic [ThresholdBits-1:0]        jump_threshold;
		logic signed [TareBits-1:0]      tare_offset;
		logic                            led_forced;
		logic [LedOnBits-1:0]            led_on_ms;
		logic [LedOffBits-1:0]           led_off_ms;
	} cfg_t;

	typedef struct packed {
		logic signed [CornerBits-1:0] weight_top_left;
		logic signed [CornerBits-1:0] weight_top_right;
		logic signed [CornerBits-1:0] weight_bottom_left;
		logic signed [CornerBits-1:0] weight_bottom_right;
		logic [TimeInBits-1:0]        time_ms;
		logic                         button_pressed;
	} sample_t;

	typedef struct packed {
		logic signed [ReportBits-1:0] reported_weight;
		logic                         weight_updated;
		logic                         startle;
		logic                         led_on;
		logic                         led_toggled;
	} result_t;

endpackage

`default_nettype wire

### rtl/core/wfjd_cfg_regs.sv
`default_nettype none

module wfjd_cfg_regs (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [wfjd_pkg::AddrBits-1:0] paddr,
	input  wire logic [wfjd_pkg::DataBits-1:0] pwdata,
	output logic [wfjd_pkg::DataBits-1:0]      prdata,
	output logic                               pready,
	output wfjd_pkg::cfg_t                     cfg
);
	import wfjd_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t reg_idx;
	logic     wr_en;

	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[AddrBits-1:2]);
	assign wr_en   = psel && penable && pwrite;
	assign cfg     = cfg_q;

	// Write the addressed register on the access cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.publish_interval_ms <= ResetPublishInterval;
			cfg_q.jump_threshold      <= ResetJumpThreshold;
			cfg_q.tare_offset         <= ResetTareOffset;
			cfg_q.led_forced          <= ResetLedForced;
			cfg_q.led_on_ms           <= ResetLedOn;
			cfg_q.led_off_ms          <= ResetLedOff;
		end else if (wr_en) begin
			unique case (reg_idx)
				RegPublishInterval: cfg_q.publish_interval_ms <= pwdata[IntervalBits-1:0];
				RegJumpThreshold:   cfg_q.jump_threshold      <= pwdata[ThresholdBits-1:0];
				RegTareOffset:      cfg_q.tare_offset         <= pwdata[TareBits-1:0];
				RegLedForced:       cfg_q.led_forced          <= pwdata[0];
				RegLedOn:           cfg_q.led_on_ms           <= pwdata[LedOnBits-1:0];
				RegLedOff:          cfg_q.led_off_ms          <= pwdata[LedOffBits-1:0];
				default:            ;
			endcase
		end
	end

	// Return the addressed register, zero above the list
	always_comb begin
		unique case (reg_idx)
			RegPublishInterval: prdata = DataBits'(cfg_q.publish_interval_ms);
			RegJumpThreshold:   prdata = DataBits'(cfg_q.jump_threshold);
			RegTareOffset:      prdata = DataBits'(unsigned'(cfg_q.tare_offset));
			RegLedForced:       prdata = DataBits'(cfg_q.led_forced);
			RegLedOn:           prdata = DataBits'(cfg_q.led_on_ms);
			RegLedOff:          prdata = DataBits'(cfg_q.led_off_ms);
			default:            prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

### rtl/core/weight_filter_jump_detector_unit.sv
`default_nettype none

// Weight filter and jump detector. Each sample request carries four signed corner
// weights (0.01 kg), a millisecond timestamp and a button bit, and yields exactly
// one result: the corner sum goes through a low-pass filter with alpha one tenth,
// then a two-point average; once per publish interval the average becomes the
// published weight, and a jump of at least the threshold (or a held button) raises
// startle. The reported weight is the published weight minus the tare offset. The
// blink LED toggles with separate on and off periods unless forced. Timing: one
// sample is accepted every cycle unless the input is stalled; a sample passes the
// input register, the filter stage and the average/publish stage into the result
// register. The filter stage holds the single divide-by-ten multiplier. A stalled
// result only holds back the input once the stages in front of it are full.
// Configuration registers sit at byte addresses 0, 4, ... 20 of the APB port:
// publish interval, jump threshold, tare offset, LED forced, LED on, LED off.
module weight_filter_jump_detector_unit (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          sample_valid,
	output logic                               sample_stall,
	input  wire wfjd_pkg::sample_t             sample,
	output logic                               result_valid,
	input  wire logic                          result_stall,
	output wfjd_pkg::result_t                  result,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [wfjd_pkg::AddrBits-1:0] paddr,
	input  wire logic [wfjd_pkg::DataBits-1:0] pwdata,
	output logic [wfjd_pkg::DataBits-1:0]      prdata,
	output logic                               pready
);
	import wfjd_pkg::*;

	// Corner sum widths and saturation limits
	localparam int SumBits = (CornerBits + 2 > WeightBits) ? CornerBits + 2 : WeightBits;
	localparam logic signed [SumBits-1:0] SumMax = SumBits'((1 << (WeightBits - 1)) - 1);
	localparam logic signed [SumBits-1:0] SumMin = -SumMax - SumBits'(1);

	// Filter arithmetic: x = sum + 9*filtered, |x| < 2^(MagBits), divided by ten
	// as a multiply by the rounded-up reciprocal, exact while |x| < 2^(Div10Shift-1)
	localparam int XBits      = WeightBits + 4;
	localparam int MagBits    = WeightBits + 3;
	localparam int Div10Shift = MagBits + 2;
	localparam int MulBits    = Div10Shift - 3;
	localparam int ProdBits   = MagBits + MulBits;
	localparam logic [MulBits-1:0] Div10Mul = MulBits'(((1 << Div10Shift) + 9) / 10);

	// Elapsed-time compares span the timer and the widest period
	localparam int CmpBits = (TimeBits > LedOffBits) ? TimeBits : LedOffBits;

	cfg_t cfg;

	wfjd_cfg_regs u_cfg_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Stage enables: a stage moves when it is empty or its successor moves
	logic en_s1, en_s2, en_res;
	logic valid_s1, valid_s2, res_valid_q;

	assign en_res       = !res_valid_q || !result_stall;
	assign en_s2        = !valid_s2 || en_res;
	assign en_s1        = !valid_s1 || en_s2;
	assign sample_stall = !en_s1;
	assign result_valid = res_valid_q;

	// Sum corners and saturate to the weight range
	logic signed [SumBits-1:0]    corner_sum;
	logic signed [WeightBits-1:0] sum_sat;

	assign corner_sum = SumBits'(sample.weight_top_left) + SumBits'(sample.weight_top_right)
		+ SumBits'(sample.weight_bottom_left) + SumBits'(sample.weight_bottom_right);

	always_comb begin
		priority if (corner_sum > SumMax) begin
			sum_sat = SumMax[WeightBits-1:0];
		end else if (corner_sum < SumMin) begin
			sum_sat = SumMin[WeightBits-1:0];
		end else begin
			sum_sat = corner_sum[WeightBits-1:0];
		end
	end

	// Input register
	logic signed [WeightBits-1:0] sum_s1;
	logic [TimeBits-1:0]          time_s1;
	logic                         button_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en_s1) begin
			valid_s1 <= sample_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && sample_valid) begin
			sum_s1    <= sum_sat;
			time_s1   <= sample.time_ms[TimeBits-1:0];
			button_s1 <= sample.button_pressed;
		end
	end

	// Filter stage: filtered = (sum + 9*filtered) / 10, truncated toward zero
	logic signed [WeightBits-1:0] filtered_q;
	logic signed [XBits-1:0]      filt_x;
	logic [MagBits-1:0]           filt_mag;
	logic [ProdBits-1:0]          filt_prod;
	logic [WeightBits-1:0]        filt_quot;
	logic signed [WeightBits-1:0] filt_new;
	logic                         move_s1;

	assign filt_x    = XBits'(sum_s1) + (XBits'(filtered_q) <<< 3) + XBits'(filtered_q);
	assign filt_mag  = filt_x[XBits-1] ? MagBits'(-filt_x) : MagBits'(filt_x);
	assign filt_prod = ProdBits'(filt_mag) * ProdBits'(Div10Mul);
	assign filt_quot = filt_prod[Div10Shift +: WeightBits];
	assign filt_new  = filt_x[XBits-1] ? -signed'(filt_quot) : signed'(filt_quot);
	assign move_s1   = valid_s1 && en_s2;

	logic [TimeBits-1:0] time_s2;
	logic                button_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2   <= 1'b0;
			filtered_q <= '0;
		end else if (en_s2) begin
			valid_s2 <= valid_s1;
			if (valid_s1) begin
				filtered_q <= filt_new;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (move_s1) begin
			time_s2   <= time_s1;
			button_s2 <= button_s1;
		end
	end

	// Average stage; filtered_q holds the value of the item in stage two
	logic signed [WeightBits-1:0] average_q;
	logic signed [WeightBits-1:0] published_q;
	logic [TimeBits-1:0]          last_publish_q;
	logic [TimeBits-1:0]          last_blink_q;
	logic                         blink_q;

	logic signed [WeightBits:0]   avg_sum;
	logic signed [WeightBits:0]   avg_adj;
	logic signed [WeightBits-1:0] avg_new;

	assign avg_sum = (WeightBits + 1)'(average_q) + (WeightBits + 1)'(filtered_q);
	assign avg_adj = avg_sum + (WeightBits + 1)'(avg_sum[WeightBits]);
	assign avg_new = avg_adj[WeightBits:1];

	// Publish decision and jump test against the old published weight
	logic [TimeBits-1:0]          pub_elapsed;
	logic                         publish;
	logic signed [WeightBits:0]   jump_diff;
	logic [WeightBits:0]          jump_mag;
	logic                         jump;
	logic signed [WeightBits-1:0] pub_new;
	logic signed [ReportBits-1:0] report;

	assign pub_elapsed = time_s2 - last_publish_q;
	assign publish     = CmpBits'(pub_elapsed) >= CmpBits'(cfg.publish_interval_ms);
	assign jump_diff   = (WeightBits + 1)'(avg_new) - (WeightBits + 1)'(published_q);
	assign jump_mag    = jump_diff[WeightBits] ? unsigned'(-jump_diff) : unsigned'(jump_diff);
	assign jump        = jump_mag >= (WeightBits + 1)'(cfg.jump_threshold);
	assign pub_new     = publish ? avg_new : published_q;
	assign report      = ReportBits'(pub_new) - ReportBits'(cfg.tare_offset);

	// Blink LED: pick the period of the current phase
	logic [TimeBits-1:0] blink_elapsed;
	logic [CmpBits-1:0]  blink_period;
	logic                toggle;

	assign blink_elapsed = time_s2 - last_blink_q;
	assign blink_period  = blink_q ? CmpBits'(cfg.led_on_ms) : CmpBits'(cfg.led_off_ms);
	assign toggle        = !cfg.led_forced && (CmpBits'(blink_elapsed) >= blink_period);

	logic move_s2;
	assign move_s2 = valid_s2 && en_res;

	// Advance state and load the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q    <= 1'b0;
			average_q      <= '0;
			published_q    <= '0;
			last_publish_q <= '0;
			last_blink_q   <= '0;
			blink_q        <= 1'b0;
		end else if (en_res) begin
			res_valid_q <= valid_s2;
			if (valid_s2) begin
				average_q <= avg_new;
				if (publish) begin
					published_q    <= avg_new;
					last_publish_q <= time_s2;
				end
				if (toggle) begin
					blink_q      <= !blink_q;
					last_blink_q <= time_s2;
				end
			end
		end
	end

	result_t result_q;

	always_ff @(posedge clk) begin
		if (move_s2) begin
			result_q.reported_weight <= report;
			result_q.weight_updated  <= publish;
			result_q.startle         <= (publish && jump) || button_s2;
			result_q.led_on          <= blink_q ^ toggle;
			result_q.led_toggled     <= toggle;
		end
	end

	assign result = result_q;

	// An empty result register never holds back the input
	assert property (@(posedge clk) disable iff (!arst_n)
		!res_valid_q |-> !sample_stall)
		else $error("input stalled with empty result register");

	// The filter state only changes when an item leaves the input register
	assert property (@(posedge clk) disable iff (!arst_n)
		!move_s1 |=> $stable(filtered_q))
		else $error("filter state changed without an item");

	// An item leaving stage two lands in the result register
	assert property (@(posedge clk) disable iff (!arst_n)
		move_s2 |=> res_valid_q)
		else $error("item lost between stage two and result");

	// A held button always shows as startle
	assert property (@(posedge clk) disable iff (!arst_n)
		(move_s2 && button_s2) |=> result.startle)
		else $error("button press did not raise startle");

	// Published weight only moves on a publishing item
	assert property (@(posedge clk) disable iff (!arst_n)
		!(move_s2 && publish) |=> $stable(published_q) && $stable(last_publish_q))
		else $error("published weight changed without a publish");

endmodule

`default_nettype wire

### bench/wfjd_checker.sv
`timescale 1ns / 1ps

// Watch the sample, result and register channels, predict each result and compare.
module wfjd_checker
	import wfjd_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                sample_valid,
	input  wire logic                sample_stall,
	input  wire sample_t             sample,
	input  wire logic                result_valid,
	input  wire logic                result_stall,
	input  wire result_t             result,
	input  wire logic                psel,
	input  wire logic                penable,
	input  wire logic                pwrite,
	input  wire logic [AddrBits-1:0] paddr,
	input  wire logic [DataBits-1:0] pwdata,
	input  wire logic                pready,
	output int                       error_count,
	output int                       pending,
	output int                       checked_count,
	output int                       startle_count,
	output int                       toggle_count
);

	localparam longint WeightMax = (longint'(1) <<< (WeightBits - 1)) - 1;
	localparam longint WeightMin = -(longint'(1) <<< (WeightBits - 1));

	// Register copy and filter state as the unit should hold them
	cfg_t                         cfg;
	logic signed [WeightBits-1:0] filtered_w;
	logic signed [WeightBits-1:0] average_w;
	logic signed [WeightBits-1:0] published_w;
	logic [TimeBits-1:0]          last_publish_ms;
	logic [TimeBits-1:0]          last_blink_ms;
	logic                         blink_led;

	result_t expected_readings [$];
	int      mismatches = 0;
	int      compared = 0;
	int      startles = 0;
	int      toggles = 0;

	function automatic longint saturate_weight(longint v);
		if (v > WeightMax) return WeightMax;
		if (v < WeightMin) return WeightMin;
		return v;
	endfunction

	// Advance the filter, publish and blink state by one sample; return its reading
	function automatic result_t filter_sample(sample_t s);
		result_t               r;
		longint                total;
		longint                jump;
		logic [TimeBits-1:0]   now;
		logic [TimeBits-1:0]   elapsed;
		logic [LedOffBits-1:0] period;
		now = s.time_ms[TimeBits-1:0];
		total = longint'(s.weight_top_left) + longint'(s.weight_top_right)
			+ longint'(s.weight_bottom_left) + longint'(s.weight_bottom_right);
		total = saturate_weight(total);
		filtered_w = WeightBits'(saturate_weight((total + 9 * longint'(filtered_w)) / 10));
		average_w = WeightBits'(saturate_weight((longint'(average_w)
			+ longint'(filtered_w)) / 2));
		r = '0;

		// Publish once the interval has passed; the jump is measured against the old value
		elapsed = now - last_publish_ms;
		if (elapsed >= TimeBits'(cfg.publish_interval_ms)) begin
			jump = longint'(average_w) - longint'(published_w);
			if (jump < 0)
				jump = -jump;
			if (jump >= longint'(cfg.jump_threshold))
				r.startle = 1'b1;
			published_w = average_w;
			last_publish_ms = now;
			r.weight_updated = 1'b1;
		end
		if (s.button_pressed)
			r.startle = 1'b1;

		// Blink with separate on and off periods; freeze while forced
		if (!cfg.led_forced) begin
			period = blink_led ? LedOffBits'(cfg.led_on_ms) : cfg.led_off_ms;
			elapsed = now - last_blink_ms;
			if (elapsed >= TimeBits'(period)) begin
				blink_led = !blink_led;
				last_blink_ms = now;
				r.led_toggled = 1'b1;
			end
		end
		r.led_on = blink_led;
		r.reported_weight = ReportBits'(longint'(published_w) - longint'(cfg.tare_offset));
		return r;
	endfunction

	function automatic void check_field(string name, longint want, longint got);
		if (want != got) begin
			mismatches++;
			$display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			cfg.publish_interval_ms = ResetPublishInterval;
			cfg.jump_threshold = ResetJumpThreshold;
			cfg.tare_offset = ResetTareOffset;
			cfg.led_forced = ResetLedForced;
			cfg.led_on_ms = ResetLedOn;
			cfg.led_off_ms = ResetLedOff;
			filtered_w = '0;
			average_w = '0;
			published_w = '0;
			last_publish_ms = '0;
			last_blink_ms = '0;
			blink_led = 1'b0;
			expected_readings.delete();
		end else begin
			// Track register writes
			if (psel && penable && pwrite && pready) begin
				case (reg_idx_t'(paddr[AddrBits-1:2]))
					RegPublishInterval: cfg.publish_interval_ms = pwdata[IntervalBits-1:0];
					RegJumpThreshold:   cfg.jump_threshold = pwdata[ThresholdBits-1:0];
					RegTareOffset:      cfg.tare_offset = pwdata[TareBits-1:0];
					RegLedForced:       cfg.led_forced = pwdata[0];
					RegLedOn:           cfg.led_on_ms = pwdata[LedOnBits-1:0];
					RegLedOff:          cfg.led_off_ms = pwdata[LedOffBits-1:0];
					default: ;
				endcase
			end

			// Compare a taken result with the oldest expected reading
			if (result_valid && !result_stall) begin
				if (expected_readings.size() == 0) begin
					mismatches++;
					$display("%0t: result with no sample request pending: expected none, actual %0d",
						$time, result.reported_weight);
				end else begin
					want = expected_readings.pop_front();
					check_field("reported_weight", want.reported_weight, result.reported_weight);
					check_field("weight_updated", want.weight_updated, result.weight_updated);
					check_field("startle", want.startle, result.startle);
					check_field("led_on", want.led_on, result.led_on);
					check_field("led_toggled", want.led_toggled, result.led_toggled);
					compared++;
					if (want.startle)
						startles++;
					if (want.led_toggled)
						toggles++;
				end
			end

			// Predict the reading of each taken sample request
			if (sample_valid && !sample_stall)
				expected_readings.push_back(filter_sample(sample));
		end
		error_count <= mismatches;
		pending <= expected_readings.size();
		checked_count <= compared;
		startle_count <= startles;
		toggle_count <= toggles;
	end

endmodule

### bench/tb_weight_filter_jump_detector_unit.sv
`timescale 1ns / 1ps

module tb_weight_filter_jump_detector_unit;
	import wfjd_pkg::*;

	localparam int RunLimitNs = 4_000_000;
	localparam int RandomPerPhase = 105;
	localparam int LongHoldCycles = 60;

	logic                clk;
	logic                arst_n;
	logic                sample_valid;
	logic                sample_stall;
	sample_t             sample;
	logic                result_valid;
	logic                result_stall;
	result_t             result;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [AddrBits-1:0] paddr;
	logic [DataBits-1:0] pwdata;
	logic [DataBits-1:0] prdata;
	logic                pready;

	int error_count;
	int pending;
	int checked_count;
	int startle_count;
	int toggle_count;

	// Stimulus state
	logic        flood_on = 1'b0;
	bit          gaps_on = 1'b1;
	int          burst_left = 0;
	int          sent_count = 0;
	int          setting_count = 1;
	logic [31:0] clock_ms;
	int          base_load [4];

	weight_filter_jump_detector_unit u_dut (
		.clk, .arst_n,
		.sample_valid, .sample_stall, .sample,
		.result_valid, .result_stall, .result,
		.psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
	);

	wfjd_checker u_checker (
		.clk, .arst_n,
		.sample_valid, .sample_stall, .sample,
		.result_valid, .result_stall, .result,
		.psel, .penable, .pwrite, .paddr, .pwdata, .pready,
		.error_count, .pending, .checked_count, .startle_count, .toggle_count
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Bound the run
	initial begin
		#RunLimitNs;
		$display("Some tests failed");
		$finish;
	end

	// Receiver: stall in segments of random style, once holding off for a long stretch
	initial begin : receiver
		int len;
		int mode;
		bit held;
		held = 1'b0;
		result_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			if (flood_on && !held) begin
				held = 1'b1;
				result_stall <= 1'b1;
				repeat (LongHoldCycles) @(posedge clk);
			end
			mode = $urandom_range(0, 3);
			len = $urandom_range(4, 40);
			repeat (len) begin
				case (mode)
					0: result_stall <= 1'b0;
					1: result_stall <= ($urandom_range(0, 3) == 0);
					2: result_stall <= $urandom_range(0, 1);
					default: result_stall <= ~result_stall;
				endcase
				@(posedge clk);
			end
		end
	end

	function automatic sample_t make_sample(logic [CornerBits-1:0] tl, logic [CornerBits-1:0] tr,
		logic [CornerBits-1:0] bl, logic [CornerBits-1:0] br, logic [31:0] t, logic button);
		sample_t s;
		s.weight_top_left = tl;
		s.weight_top_right = tr;
		s.weight_bottom_left = bl;
		s.weight_bottom_right = br;
		s.time_ms = t;
		s.button_pressed = button;
		return s;
	endfunction

	// Build a plausible sample: steady load with jitter, time mostly moving forward, some noise
	function automatic sample_t random_sample(int step_max);
		int corner [4];
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 8)
			clock_ms = $urandom;
		else if (pick >= 13)
			clock_ms = clock_ms + $urandom_range(0, step_max);
		// step the load on the plate now and then
		if ($urandom_range(0, 11) == 0)
			foreach (base_load[k])
				base_load[k] = $urandom_range(0, 65535) - 32768;
		foreach (corner[k]) begin
			if (pick >= 90)
				corner[k] = $urandom_range(0, 65535) - 32768;
			else
				corner[k] = base_load[k] + $urandom_range(0, 64) - 32;
			if (corner[k] > 32767)
				corner[k] = 32767;
			if (corner[k] < -32768)
				corner[k] = -32768;
		end
		return make_sample(CornerBits'(corner[0]), CornerBits'(corner[1]),
			CornerBits'(corner[2]), CornerBits'(corner[3]), clock_ms,
			$urandom_range(0, 9) == 0);
	endfunction

	// Offer one sample request, pausing between bursts, and hold it until taken
	task automatic send_sample(input sample_t s);
		int gap;
		if (burst_left == 0) begin
			gap = (gaps_on && $urandom_range(0, 3) != 0) ? $urandom_range(1, 6) : 0;
			burst_left = $urandom_range(1, 20);
			if (gap > 0) begin
				sample_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		sample <= s;
		sample_valid <= 1'b1;
		do @(posedge clk); while (sample_stall);
		sent_count++;
	endtask

	// Drop valid and wait until every reading has come back
	task automatic settle();
		sample_valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// One APB write; psel stays up so writes can follow back to back
	task automatic write_reg(input reg_idx_t idx, input logic [DataBits-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
	endtask

	task automatic configure(input logic [DataBits-1:0] publish_ms, threshold, tare, forced,
		on_ms, off_ms);
		write_reg(RegPublishInterval, publish_ms);
		write_reg(RegJumpThreshold, threshold);
		write_reg(RegTareOffset, tare);
		write_reg(RegLedForced, forced);
		write_reg(RegLedOn, on_ms);
		write_reg(RegLedOff, off_ms);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		setting_count++;
	endtask

	task automatic configure_random();
		configure($urandom_range(1, 400),
			($urandom_range(0, 3) == 0) ? $urandom_range(0, 262143) : $urandom_range(0, 8000),
			$urandom_range(0, 262143), $urandom_range(0, 1),
			$urandom_range(1, 300), $urandom_range(1, 1500));
	endtask

	task automatic run_random(input int step_max);
		repeat (RandomPerPhase) send_sample(random_sample(step_max));
		settle();
	endtask

	initial begin
		arst_n = 1'b0;
		sample_valid = 1'b0;
		sample = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		foreach (base_load[k])
			base_load[k] = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: corner extremes, button, LED periods and timestamp wrap at reset values
		send_sample(make_sample(16'h0000, 16'h0000, 16'h0000, 16'h0000, 32'd0, 1'b0));
		send_sample(make_sample(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 32'd100, 1'b0));
		send_sample(make_sample(16'h8000, 16'h8000, 16'h8000, 16'h8000, 32'd150, 1'b1));
		send_sample(make_sample(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 32'd250, 1'b0));
		send_sample(make_sample(16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF, 32'd350, 1'b0));
		send_sample(make_sample(16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555, 32'd450, 1'b0));
		send_sample(make_sample(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 32'd120000, 1'b0));
		send_sample(make_sample(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 32'd120124, 1'b0));
		send_sample(make_sample(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 32'd120125, 1'b0));
		send_sample(make_sample(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 32'hFFFF_FFF0, 1'b1));
		send_sample(make_sample(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 32'h0000_0050, 1'b0));
		send_sample(make_sample(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 32'h0000_0054, 1'b0));
		send_sample(make_sample(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 32'h0000_006D, 1'b0));
		send_sample(make_sample(16'h0000, 16'h0000, 16'h0000, 16'h0000, 32'h8000_0000, 1'b1));
		clock_ms = 32'h8000_0000;
		run_random(150);

		// Low extremes: publish every ms, any change startles, most negative tare
		configure(32'd1, 32'd0, 32'h0002_0000, 32'd0, 32'd1, 32'd1);
		run_random(4);

		// High extremes with the LED frozen
		configure(32'd65535, 32'd262143, 32'h0001_FFFF, 32'd1, 32'd65535, 32'd1048575);
		run_random(40000);

		// Zero interval and periods: every sample publishes and toggles
		configure(32'd0, 32'd500, 32'd0, 32'd0, 32'd0, 32'd0);
		run_random(10);

		// Stream without gaps while the receiver holds off, so the unit backs up
		gaps_on = 1'b0;
		flood_on = 1'b1;
		configure_random();
		run_random(200);
		flood_on = 1'b0;
		gaps_on = 1'b1;

		repeat (2) begin
			configure_random();
			run_random(200);
		end

		// Drain with a bound, then give the verdict
		begin : drain
			int waited;
			waited = 0;
			while (pending != 0 && waited < 2000) begin
				@(posedge clk);
				waited++;
			end
		end
		repeat (8) @(posedge clk);
		$display("Covered %0d samples over %0d register settings, %0d readings compared.",
			sent_count, setting_count, checked_count);
		$display("Startle seen %0d times, LED toggled %0d times, one long receiver hold-off.",
			startle_count, toggle_count);
		if (error_count == 0 && pending == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
